// File: rtl/core/tkslp_pkg.sv
// Shared types and constants for the two-key short/long press classifier.
`default_nettype none

package tkslp_pkg;

    // Configuration port geometry and register map.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic REG_IDX_LONG_PRESS = 1'b0;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd800;

    // Stream payload widths.
    localparam int unsigned SCAN_DATA_W = 40;
    localparam int unsigned EVENT_DATA_W = 8;

    // Press event codes.
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_ONE_SHORT = 3'd1;
    localparam logic [2:0] EV_ONE_LONG  = 3'd2;
    localparam logic [2:0] EV_TWO_SHORT = 3'd3;
    localparam logic [2:0] EV_TWO_LONG  = 3'd4;

    // Classifier phase. The unused code behaves as idle.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_JUDGE = 2'd1,
        PH_WAIT  = 2'd2
    } t_phase;

    // One scan, as unpacked from the input stream.
    typedef struct packed {
        logic [31:0] now_ticks;
        logic        key_two_fell;
        logic        key_one_fell;
        logic        key_two_level;
        logic        key_one_level;
    } t_scan;

endpackage

`default_nettype wire

// File: rtl/core/two_key_short_long_press_classifier.sv
// Top level of the two-key short/long press classifier.
//
// The input stream carries one scan per item: both active-low key levels,
// the falling-edge flags seen since the previous scan and the current 32-bit
// tick count. For every scan the block returns exactly one item on the output
// stream holding a press event code: none, key one short or long, key two
// short or long.
//
// An accepted scan lands in an input register. From there the phase machine
// classifies it combinationally and the event goes into the output register
// as soon as that register is empty or being emptied. A new scan can be
// accepted every cycle while the receiver takes events; the sustained rate
// is then one item per clock.
//
// When the receiver stalls, the output register holds its event, the input
// register fills with the next scan, and only then does the input stop taking
// items; nothing is dropped. Synchronous reset empties both registers, clears
// the pending flags and start times, puts the machine in idle and loads the
// threshold with 800 ticks. The user writes the threshold over the APB port
// at address 0 while the block is idle; the block does not enforce this.
`default_nettype none

module two_key_short_long_press_classifier (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Scan stream.
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // Bits from the lowest: key_one_level, key_two_level, key_one_fell,
    // key_two_fell, now_ticks[31:0], four zero bits.
    input  wire logic [tkslp_pkg::SCAN_DATA_W-1:0] i_s_axis_tdata,
    // Event stream.
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // Bits from the lowest: press_event[2:0], five zero bits.
    output logic      [tkslp_pkg::EVENT_DATA_W-1:0] o_m_axis_tdata,
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tkslp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tkslp_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tkslp_pkg::APB_DATA_W-1:0] prdata,
    output logic                                  pready
);
    import tkslp_pkg::*;

    logic        r_in_valid;
    t_scan       r_in_scan;
    logic        r_out_valid;
    logic [2:0]  r_out_event;

    logic        adv;
    logic [2:0]  event_code;
    logic [15:0] long_press_ticks;

    // The scan in the input register moves on whenever the output register
    // is empty or being emptied this cycle.
    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_scan <= i_s_axis_tdata[35:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_event <= event_code;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(EVENT_DATA_W-3){1'b0}}, r_out_event};

    tkslp_cfg u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_long_press_ticks (long_press_ticks)
    );

    tkslp_fsm u_fsm (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_adv              (adv),
        .i_scan             (r_in_scan),
        .i_long_press_ticks (long_press_ticks),
        .o_event            (event_code)
    );

endmodule

`default_nettype wire

// File: rtl/core/tkslp_cfg.sv
// APB register block holding the long-press threshold.
`default_nettype none

module tkslp_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tkslp_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tkslp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tkslp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    output logic      [15:0]                       o_long_press_ticks
);
    import tkslp_pkg::*;

    logic [15:0] r_long_press_ticks;
    logic        hit;

    assign hit = (paddr[2] == REG_IDX_LONG_PRESS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= LONG_PRESS_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_long_press_ticks <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = hit ? {{(APB_DATA_W-16){1'b0}}, r_long_press_ticks} : '0;
    assign o_long_press_ticks = r_long_press_ticks;

endmodule

`default_nettype wire

// File: rtl/core/tkslp_fsm.sv
// Phase machine, pending flags and start times; classifies one scan per cycle while i_adv is high.
`default_nettype none

module tkslp_fsm (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire tkslp_pkg::t_scan i_scan,
    input  wire logic [15:0]      i_long_press_ticks,
    output logic      [2:0]       o_event
);
    import tkslp_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_one_pend, n_one_pend;
    logic        r_two_pend, n_two_pend;
    logic [31:0] r_one_start, n_one_start;
    logic [31:0] r_two_start, n_two_start;

    logic        one_pend, two_pend;
    logic [31:0] one_elapsed, two_elapsed;
    logic        one_long, two_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_one_pend  <= 1'b0;
            r_two_pend  <= 1'b0;
            r_one_start <= '0;
            r_two_start <= '0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_one_pend  <= n_one_pend;
            r_two_pend  <= n_two_pend;
            r_one_start <= n_one_start;
            r_two_start <= n_two_start;
        end
    end

    // Edge events of this scan join the flags before the phase logic looks at them.
    assign one_pend    = r_one_pend | i_scan.key_one_fell;
    assign two_pend    = r_two_pend | i_scan.key_two_fell;
    assign one_elapsed = i_scan.now_ticks - r_one_start;
    assign two_elapsed = i_scan.now_ticks - r_two_start;
    assign one_long    = (one_elapsed >= {16'd0, i_long_press_ticks});
    assign two_long    = (two_elapsed >= {16'd0, i_long_press_ticks});

    always_comb begin
        n_phase     = r_phase;
        n_one_pend  = one_pend;
        n_two_pend  = two_pend;
        n_one_start = r_one_start;
        n_two_start = r_two_start;
        o_event     = EV_NONE;
        unique case (r_phase)
            PH_JUDGE: begin
                // Key one wins whenever its flag is up.
                if (one_pend) begin
                    if (i_scan.key_one_level) begin
                        o_event = EV_ONE_SHORT;
                    end else if (one_long) begin
                        o_event = EV_ONE_LONG;
                    end
                    if (i_scan.key_one_level || one_long) begin
                        n_one_pend = 1'b0;
                        n_phase    = PH_WAIT;
                    end
                end else if (two_pend) begin
                    if (i_scan.key_two_level) begin
                        o_event = EV_TWO_SHORT;
                    end else if (two_long) begin
                        o_event = EV_TWO_LONG;
                    end
                    if (i_scan.key_two_level || two_long) begin
                        n_two_pend = 1'b0;
                        n_phase    = PH_WAIT;
                    end
                end
            end
            PH_WAIT: begin
                if (i_scan.key_one_level && i_scan.key_two_level) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                // Idle, and the unused code, which behaves as idle.
                if (one_pend || two_pend) begin
                    n_phase = PH_JUDGE;
                    if (one_pend) begin
                        n_one_start = i_scan.now_ticks;
                    end
                    if (two_pend) begin
                        n_two_start = i_scan.now_ticks;
                    end
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire
